@@ rtl/lvs_pkg.sv @@
// ----------------------------------------------------------------------------
// lvs_pkg
// Shared types for the Lucas V sequence modular core: controller states,
// matrix product modes and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lvs_pkg;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PRE,
		S_RED,
		S_DISPATCH,
		S_LOOP,
		S_START,
		S_WAIT,
		S_COMMIT,
		S_PUSH
	} state_t;

	typedef enum logic [1:0] {
		MODE_ACC,
		MODE_SQR,
		MODE_FINAL
	} mode_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_TWO,
		RES_ARED,
		RES_C0
	} res_sel_t;

	localparam logic [2:0] LAST_TERM_MAT   = 3'd7;
	localparam logic [2:0] LAST_TERM_FINAL = 3'd1;

	typedef struct packed {
		logic     load;
		logic     start_red;
		logic     save_red;
		logic     init;
		logic     start_mul;
		logic     acc_step;
		logic     commit_acc;
		logic     commit_base;
		logic     set_res;
		res_sel_t res_sel;
		logic     push;
		mode_t    mode;
		logic [2:0] term;
	} cmd_t;

	typedef struct packed {
		logic m_one;
		logic idx_zero;
		logic idx_one;
		logic exp_zero;
		logic exp_lsb;
		logic mul_done;
		logic mul_busy;
		logic out_busy;
	} sts_t;

endpackage

@@ rtl/lvs_req_if.sv @@
// ----------------------------------------------------------------------------
// lvs_req_if
// Request channel: alpha, index and modulus with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lvs_req_if #(
	parameter int WORD_BITS = 64
);
	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] alpha;
	logic [WORD_BITS-1:0] index;
	logic [WORD_BITS-1:0] modulus;

	modport source (output valid, output alpha, output index, output modulus, input ready);
	modport sink   (input valid, input alpha, input index, input modulus, output ready);
endinterface

// ----------------------------------------------------------------------------
// lvs_rsp_if
// Response channel: one sequence term with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lvs_rsp_if #(
	parameter int WORD_BITS = 64
);
	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] term;

	modport source (output valid, output term, input ready);
	modport sink   (input valid, input term, output ready);
endinterface

@@ rtl/lvs_mulmod.sv @@
// ----------------------------------------------------------------------------
// lvs_mulmod
// Shift-and-add modular multiplier. One multiplier bit per cycle, MSB first,
// giving x * y mod m on prod when done pulses. The x operand must be below m.
// ----------------------------------------------------------------------------
module lvs_mulmod #(
	parameter int WORD_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] x,
	input  logic [WORD_BITS-1:0] y,
	input  logic [WORD_BITS-1:0] m,
	output logic                 busy,
	output logic                 done,
	output logic [WORD_BITS-1:0] prod
);
	localparam int CW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam logic [CW-1:0] CNT_LAST = CW'(WORD_BITS - 1);

	function automatic logic [WORD_BITS-1:0] add_mod(
		input logic [WORD_BITS-1:0] a,
		input logic [WORD_BITS-1:0] b,
		input logic [WORD_BITS-1:0] md
	);
		logic [WORD_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, md}) begin
			s = s - {1'b0, md};
		end
		return s[WORD_BITS-1:0];
	endfunction

	logic [WORD_BITS-1:0] r_q;
	logic [WORD_BITS-1:0] x_q;
	logic [WORD_BITS-1:0] y_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [WORD_BITS-1:0] dbl;
	logic [WORD_BITS-1:0] nxt;

	always_comb begin
		dbl = add_mod(r_q, r_q, m);
		nxt = y_q[WORD_BITS-1] ? add_mod(dbl, x_q, m) : dbl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			x_q <= x;
			y_q <= y;
		end else if (busy_q) begin
			r_q <= nxt;
			y_q <= y_q << 1;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign prod = r_q;
endmodule

@@ rtl/lvs_datapath.sv @@
// ----------------------------------------------------------------------------
// lvs_datapath
// Operand registers, accumulator and base matrices, exponent shifter, the
// shared modular multiplier and the output register.
// ----------------------------------------------------------------------------
module lvs_datapath #(
	parameter int WORD_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lvs_pkg::cmd_t        cmd,
	output lvs_pkg::sts_t        sts,
	input  logic [WORD_BITS-1:0] in_alpha,
	input  logic [WORD_BITS-1:0] in_index,
	input  logic [WORD_BITS-1:0] in_modulus,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [WORD_BITS-1:0] out_term
);
	localparam logic [WORD_BITS-1:0] ONE = WORD_BITS'(1);
	localparam logic [WORD_BITS-1:0] TWO = WORD_BITS'(2);

	function automatic logic [WORD_BITS-1:0] add_mod(
		input logic [WORD_BITS-1:0] a,
		input logic [WORD_BITS-1:0] b,
		input logic [WORD_BITS-1:0] md
	);
		logic [WORD_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, md}) begin
			s = s - {1'b0, md};
		end
		return s[WORD_BITS-1:0];
	endfunction

	logic [WORD_BITS-1:0] alpha_q;
	logic [WORD_BITS-1:0] index_q;
	logic [WORD_BITS-1:0] m_q;
	logic [WORD_BITS-1:0] ared_q;
	logic [WORD_BITS-1:0] two_q;
	logic [WORD_BITS-1:0] exp_q;
	logic [WORD_BITS-1:0] acc_q  [4];
	logic [WORD_BITS-1:0] base_q [4];
	logic [WORD_BITS-1:0] c_q    [4];
	logic [WORD_BITS-1:0] res_q;
	logic [WORD_BITS-1:0] term_q;
	logic                 out_valid_q;

	logic [1:0]           k;
	logic                 h;
	logic [1:0]           ai;
	logic [1:0]           bi;
	logic [WORD_BITS-1:0] a_op;
	logic [WORD_BITS-1:0] b_op;
	logic [WORD_BITS-1:0] mul_x;
	logic [WORD_BITS-1:0] mul_y;
	logic                 mul_start;
	logic                 mul_busy;
	logic                 mul_done;
	logic [WORD_BITS-1:0] prod;

	always_comb begin
		k  = cmd.term[2:1];
		h  = cmd.term[0];
		ai = {k[1], h};
		bi = {h, k[0]};
		a_op = (cmd.mode == lvs_pkg::MODE_SQR) ? base_q[ai] : acc_q[ai];
		case (cmd.mode)
			lvs_pkg::MODE_FINAL: b_op = h ? two_q : ared_q;
			default:             b_op = base_q[bi];
		endcase
		if (cmd.start_red) begin
			mul_x = ONE;
			mul_y = alpha_q;
		end else begin
			mul_x = a_op;
			mul_y = b_op;
		end
		mul_start = cmd.start_red | cmd.start_mul;
	end

	lvs_mulmod #(
		.WORD_BITS(WORD_BITS)
	) u_mulmod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.x     (mul_x),
		.y     (mul_y),
		.m     (m_q),
		.busy  (mul_busy),
		.done  (mul_done),
		.prod  (prod)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			alpha_q <= in_alpha;
			index_q <= in_index;
			m_q     <= in_modulus;
		end
		if (cmd.save_red) begin
			ared_q <= prod;
			two_q  <= (m_q == TWO) ? '0 : TWO;
		end
		if (cmd.init) begin
			acc_q[0]  <= ONE;
			acc_q[1]  <= '0;
			acc_q[2]  <= '0;
			acc_q[3]  <= ONE;
			base_q[0] <= ared_q;
			base_q[1] <= m_q - ONE;
			base_q[2] <= ONE;
			base_q[3] <= '0;
		end
		if (cmd.acc_step) begin
			c_q[k] <= h ? add_mod(c_q[k], prod, m_q) : prod;
		end
		if (cmd.commit_acc) begin
			acc_q <= c_q;
		end
		if (cmd.commit_base) begin
			base_q <= c_q;
		end
		if (cmd.set_res) begin
			case (cmd.res_sel)
				lvs_pkg::RES_TWO:  res_q <= two_q;
				lvs_pkg::RES_ARED: res_q <= ared_q;
				lvs_pkg::RES_C0:   res_q <= c_q[0];
				default:           res_q <= '0;
			endcase
		end
		if (cmd.push) begin
			term_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.init) begin
				exp_q <= index_q - ONE;
			end else if (cmd.commit_base) begin
				exp_q <= exp_q >> 1;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.m_one    = (m_q <= ONE);
		sts.idx_zero = (index_q == '0);
		sts.idx_one  = (index_q == ONE);
		sts.exp_zero = (exp_q == '0);
		sts.exp_lsb  = exp_q[0];
		sts.mul_done = mul_done;
		sts.mul_busy = mul_busy;
		sts.out_busy = out_valid_q;
	end

	assign out_valid = out_valid_q;
	assign out_term  = term_q;
endmodule

@@ rtl/lvs_ctrl.sv @@
// ----------------------------------------------------------------------------
// lvs_ctrl
// Controller: sequences the reduction of alpha, the square-and-multiply
// loop over the exponent bits, the eight products of each matrix product
// and the final combination, and hands the term to the output register.
// ----------------------------------------------------------------------------
module lvs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  lvs_pkg::sts_t sts,
	output lvs_pkg::cmd_t cmd
);
	lvs_pkg::state_t state_q, state_d;
	lvs_pkg::mode_t  mode_q, mode_d;
	logic [2:0]      term_q, term_d;
	logic            last_term;

	assign last_term = (mode_q == lvs_pkg::MODE_FINAL) ?
		(term_q == lvs_pkg::LAST_TERM_FINAL) : (term_q == lvs_pkg::LAST_TERM_MAT);

	always_comb begin
		state_d = state_q;
		mode_d  = mode_q;
		term_d  = term_q;
		case (state_q)
			lvs_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = lvs_pkg::S_PRE;
				end
			end
			lvs_pkg::S_PRE: begin
				state_d = sts.m_one ? lvs_pkg::S_PUSH : lvs_pkg::S_RED;
			end
			lvs_pkg::S_RED: begin
				if (sts.mul_done) begin
					state_d = lvs_pkg::S_DISPATCH;
				end
			end
			lvs_pkg::S_DISPATCH: begin
				if (sts.idx_zero || sts.idx_one) begin
					state_d = lvs_pkg::S_PUSH;
				end else begin
					state_d = lvs_pkg::S_LOOP;
				end
			end
			lvs_pkg::S_LOOP: begin
				term_d  = '0;
				state_d = lvs_pkg::S_START;
				if (sts.exp_zero) begin
					mode_d = lvs_pkg::MODE_FINAL;
				end else if (sts.exp_lsb) begin
					mode_d = lvs_pkg::MODE_ACC;
				end else begin
					mode_d = lvs_pkg::MODE_SQR;
				end
			end
			lvs_pkg::S_START: begin
				state_d = lvs_pkg::S_WAIT;
			end
			lvs_pkg::S_WAIT: begin
				if (sts.mul_done) begin
					if (last_term) begin
						state_d = lvs_pkg::S_COMMIT;
					end else begin
						term_d  = term_q + 3'd1;
						state_d = lvs_pkg::S_START;
					end
				end
			end
			lvs_pkg::S_COMMIT: begin
				case (mode_q)
					lvs_pkg::MODE_ACC: begin
						mode_d  = lvs_pkg::MODE_SQR;
						term_d  = '0;
						state_d = lvs_pkg::S_START;
					end
					lvs_pkg::MODE_SQR: state_d = lvs_pkg::S_LOOP;
					default:           state_d = lvs_pkg::S_PUSH;
				endcase
			end
			lvs_pkg::S_PUSH: begin
				if (!sts.out_busy) begin
					state_d = lvs_pkg::S_IDLE;
				end
			end
			default: state_d = lvs_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.mode    = mode_q;
		cmd.term    = term_q;
		cmd.res_sel = lvs_pkg::RES_ZERO;
		in_ready    = 1'b0;
		case (state_q)
			lvs_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			lvs_pkg::S_PRE: begin
				if (sts.m_one) begin
					cmd.set_res = 1'b1;
				end else begin
					cmd.start_red = 1'b1;
				end
			end
			lvs_pkg::S_RED: begin
				cmd.save_red = sts.mul_done;
			end
			lvs_pkg::S_DISPATCH: begin
				if (sts.idx_zero) begin
					cmd.set_res = 1'b1;
					cmd.res_sel = lvs_pkg::RES_TWO;
				end else if (sts.idx_one) begin
					cmd.set_res = 1'b1;
					cmd.res_sel = lvs_pkg::RES_ARED;
				end else begin
					cmd.init = 1'b1;
				end
			end
			lvs_pkg::S_START: begin
				cmd.start_mul = 1'b1;
			end
			lvs_pkg::S_WAIT: begin
				cmd.acc_step = sts.mul_done;
			end
			lvs_pkg::S_COMMIT: begin
				case (mode_q)
					lvs_pkg::MODE_ACC: cmd.commit_acc  = 1'b1;
					lvs_pkg::MODE_SQR: cmd.commit_base = 1'b1;
					default: begin
						cmd.set_res = 1'b1;
						cmd.res_sel = lvs_pkg::RES_C0;
					end
				endcase
			end
			lvs_pkg::S_PUSH: begin
				cmd.push = !sts.out_busy;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lvs_pkg::S_IDLE;
			mode_q  <= lvs_pkg::MODE_ACC;
			term_q  <= '0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			term_q  <= term_d;
		end
	end
endmodule

@@ rtl/lucas_v_sequence_mod_core.sv @@
// ----------------------------------------------------------------------------
// lucas_v_sequence_mod_core
// Lucas V sequence term S_n mod m (Q = 1) by square-and-multiply powering of
// the matrix [[alpha, m-1], [1, 0]] on one shared bit-serial multiplier.
//
//   Channel | Modport | Payload                   | Beat
//   req     | sink    | alpha, index, modulus     | one request
//   rsp     | source  | term                      | one result per request
//
// Each matrix product is worked as eight modular products in turn.
// One request is worked on at a time; the next one is taken while the
// previous result still waits in the output register.
// Reset is asynchronous and leaves the core idle with no result pending.
// ----------------------------------------------------------------------------
module lucas_v_sequence_mod_core #(
	parameter int WORD_BITS = 64
) (
	input logic          clk,
	input logic          arst_n,
	lvs_req_if.sink      req,
	lvs_rsp_if.source    rsp
);
	lvs_pkg::cmd_t cmd;
	lvs_pkg::sts_t sts;

	lvs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	lvs_datapath #(
		.WORD_BITS(WORD_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_alpha  (req.alpha),
		.in_index  (req.index),
		.in_modulus(req.modulus),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.out_term  (rsp.term)
	);

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.start_mul || cmd.start_red) |-> !sts.mul_busy)
		else $error("Multiplier started while busy.");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !sts.out_busy)
		else $error("Result pushed over a pending result.");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("Second request taken while one is in work.");

	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.ready) |=> !rsp.valid)
		else $error("Result repeated after its beat.");
endmodule
